// File: design/akhl_pkg.sv
// ----------------------------------------------------------------------------
// akhl_pkg
// Shared types, sizes and the keyword table of the keyword and hex lexer.
// ----------------------------------------------------------------------------
package akhl_pkg;

  localparam int KEYWORD_LEN = 5;
  localparam int VALUE_BITS  = 32;
  localparam int KW_COUNT    = 41;
  localparam int CHAR_W      = 8;
  localparam int LEN_W       = $clog2(KEYWORD_LEN + 1);
  localparam int CODE_W      = 6;
  localparam int NUMBER_W    = 32;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_KEYWORD = 2'd0,
    KIND_NUMBER  = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [CODE_W-1:0]   code;
    logic [NUMBER_W-1:0] value;
    logic                last;
  } result_t;

  // Up to two results leave the lexer for one character.
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

  // Keyword text, right aligned and zero padded on the left.
  localparam logic [CHAR_W*KEYWORD_LEN-1:0] KW_TEXT [KW_COUNT] = '{
    "SYS", "CLS", "RET", "JMP", "CALL", "SE", "SNE", "SKP", "SNKP", "KEY",
    "MOV", "ADD", "SUB", "RSB", "OR", "AND", "XOR", "SHR", "SHL", "RND",
    "DRW", "LDFNT", "BCD", "STR", "LDR",
    "V0", "V1", "V2", "V3", "V4", "V5", "V6", "V7",
    "V8", "V9", "VA", "VB", "VC", "VD", "VE", "VF"
  };

  function automatic logic [LEN_W-1:0] kw_len(input int k);
    logic [LEN_W-1:0] n;
    n = '0;
    for (int i = 0; i < KEYWORD_LEN; i++) begin
      if (KW_TEXT[k][CHAR_W*i +: CHAR_W] != '0) n = n + 1'b1;
    end
    return n;
  endfunction

  // Character at position p of keyword k, counted from its first character.
  function automatic logic [CHAR_W-1:0] kw_char(input int k, input int p);
    int len;
    len = int'(kw_len(k));
    if (p < len) return KW_TEXT[k][CHAR_W*(len-1-p) +: CHAR_W];
    return '0;
  endfunction

endpackage

// File: design/assembler_keyword_hex_lexer_top.sv
// Path: a character waits in the input register, its results go to the result queue and are
// offered on the output from there; a queue without room keeps the character waiting.
// Throughput: one character per cycle; a character that yields two tokens writes both into
// the queue together, and the input stalls when the four-entry queue has no room for two.
// Reset: synchronous, active low; empties the input register, the queue and the token state.
// ----------------------------------------------------------------------------
// assembler_keyword_hex_lexer_top
// Lexer for assembler keywords, V registers and 0x hex literals.
// ----------------------------------------------------------------------------
module assembler_keyword_hex_lexer_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [akhl_pkg::CHAR_W-1:0]   in_text_char,
  input  logic                          in_end_of_text,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_token_kind,
  output logic [akhl_pkg::CODE_W-1:0]   out_keyword_code,
  output logic [akhl_pkg::NUMBER_W-1:0] out_number_value,
  output logic                          out_last_of_run
);
  import akhl_pkg::*;

  push_t   push;
  logic    q_room;
  result_t head;

  akhl_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_text_char   (in_text_char),
    .in_end_of_text (in_end_of_text),
    .q_room         (q_room),
    .push           (push)
  );

  akhl_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (q_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_token_kind   = head.kind;
  assign out_keyword_code = head.code;
  assign out_number_value = head.value;
  assign out_last_of_run  = head.last;

  a_push_room : assert property (@(posedge clk) disable iff (!rst_n)
    (push.count != 2'd0) |-> q_room)
    else $error("results pushed into a full queue");

  a_push_last : assert property (@(posedge clk) disable iff (!rst_n)
    ((push.count == 2'd1) |-> push.r0.last) and
    ((push.count == 2'd2) |-> (!push.r0.last && push.r1.last)))
    else $error("last flag misplaced in a request");

  a_push_count : assert property (@(posedge clk) disable iff (!rst_n)
    push.count != 2'd3)
    else $error("more than two results for one character");

  a_push_shown : assert property (@(posedge clk) disable iff (!rst_n)
    (push.count != 2'd0) |=> out_valid)
    else $error("pushed result not offered on the output");

endmodule

// File: design/akhl_outq.sv
// ----------------------------------------------------------------------------
// akhl_outq
// Result queue: takes up to two results a cycle, pops one a cycle on ready.
// ----------------------------------------------------------------------------
module akhl_outq (
  input  logic            clk,
  input  logic            rst_n,
  input  akhl_pkg::push_t push,
  output logic            room,
  output logic            out_valid,
  input  logic            out_ready,
  output akhl_pkg::result_t head
);
  import akhl_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  result_t            q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [PTR_W-1:0]   tail_r, tail_nxt;
  logic [PTR_W-1:0]   tail_p1;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               pop;

  assign room      = (count_r <= CNT_W'(QUEUE_DEPTH - 2));
  assign out_valid = (count_r != '0);
  assign head      = q_r[head_r];
  assign pop       = out_valid && out_ready;
  assign tail_p1   = tail_r + 1'b1;

  always_comb begin
    head_nxt  = pop ? PTR_W'(head_r + 1'b1) : head_r;
    tail_nxt  = tail_r + PTR_W'(push.count);
    count_nxt = count_r + CNT_W'(push.count) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      q_r[tail_r] <= push.r0;
    end
    if (push.count == 2'd2) begin
      q_r[tail_p1] <= push.r1;
    end
  end

endmodule

// File: design/akhl_core.sv
// ----------------------------------------------------------------------------
// akhl_core
// Input register and token state: one character is lexed per cycle while the result queue has room.
// ----------------------------------------------------------------------------
module akhl_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [akhl_pkg::CHAR_W-1:0]  in_text_char,
  input  logic                         in_end_of_text,
  input  logic                         q_room,
  output akhl_pkg::push_t              push
);
  import akhl_pkg::*;

  typedef enum logic [3:0] {
    MODE_EMPTY   = 4'b0001,
    MODE_KEYWORD = 4'b0010,
    MODE_ZERO    = 4'b0100,
    MODE_HEX     = 4'b1000
  } mode_t;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_X     = 8'h78;

  localparam result_t ERR_RES = '{kind: KIND_ERROR, code: '0, value: '0, last: 1'b0};

  // Input register.
  logic              s1_v_r;
  logic [CHAR_W-1:0] s1_char_r;
  logic              s1_eot_r;
  logic              fire;

  // Token state. The keyword prefix is kept as the set of keywords it still fits.
  mode_t                 mode_r, mode_nxt;
  logic [KW_COUNT-1:0]   cand_r, cand_nxt;
  logic [LEN_W-1:0]      plen_r, plen_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic                  seen_r, seen_nxt;
  logic                  cmt_r, cmt_nxt;
  logic                  err_r, err_nxt;

  logic [CHAR_W-1:0]   c;
  logic                is_end;
  logic                is_delim;
  logic [KW_COUNT-1:0] kwx;
  logic [KW_COUNT-1:0] kw0;
  logic [KW_COUNT-1:0] kwm;
  logic                kw_ext;
  logic                kw0_ext;
  logic [CODE_W-1:0]   match_code;
  logic                hex_ok;
  logic [3:0]          hex_val;
  logic                ovf;
  result_t             fl;
  logic                fl_err;
  logic [1:0]          n;
  result_t             r0, r1;

  assign fire     = s1_v_r && q_room;
  assign in_ready = !s1_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_v_r <= 1'b1;
    end else if (fire) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char_r <= in_text_char;
      s1_eot_r  <= in_end_of_text;
    end
  end

  assign c        = s1_char_r;
  assign is_end   = s1_eot_r || (c == CH_NUL);
  assign is_delim = c inside {CH_NL, CH_SEMI, CH_SPACE, CH_TAB, CH_COMMA};

  always_comb begin
    for (int k = 0; k < KW_COUNT; k++) begin
      kwx[k] = cand_r[k] && (kw_len(k) > plen_r) && (kw_char(k, int'(plen_r)) == c);
      kw0[k] = (kw_char(k, 0) == c);
      kwm[k] = cand_r[k] && (kw_len(k) == plen_r);
    end
    match_code = '0;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (kwm[k]) match_code = CODE_W'(k);
    end
  end

  assign kw_ext  = ((mode_r == MODE_EMPTY) || (mode_r == MODE_KEYWORD)) &&
                   (plen_r < LEN_W'(KEYWORD_LEN)) && (|kwx);
  assign kw0_ext = |kw0;
  assign ovf     = |acc_r[VALUE_BITS-1 -: 4];

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = c[3:0];
    if (c inside {[8'h30:8'h39]}) begin
      hex_val = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      hex_val = c[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  // Token that the current buffer gives when it is ended.
  always_comb begin
    fl     = ERR_RES;
    fl_err = 1'b1;
    if ((mode_r == MODE_KEYWORD) && (|kwm)) begin
      fl.kind = KIND_KEYWORD;
      fl.code = match_code;
      fl_err  = 1'b0;
    end else if ((mode_r == MODE_HEX) && seen_r) begin
      fl.kind  = KIND_NUMBER;
      fl.value = NUMBER_W'(acc_r);
      fl_err   = 1'b0;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    cand_nxt = cand_r;
    plen_nxt = plen_r;
    acc_nxt  = acc_r;
    seen_nxt = seen_r;
    cmt_nxt  = cmt_r;
    err_nxt  = err_r;
    n        = 2'd0;
    r0       = fl;
    r1       = ERR_RES;
    if (fire) begin
      if (is_end) begin
        if (!err_r && (mode_r != MODE_EMPTY)) n = 2'd1;
        mode_nxt = MODE_EMPTY;
        cand_nxt = '1;
        plen_nxt = '0;
        acc_nxt  = '0;
        seen_nxt = 1'b0;
        cmt_nxt  = 1'b0;
        err_nxt  = 1'b0;
      end else if (err_r) begin
        n = 2'd0;
      end else if (cmt_r) begin
        if (c == CH_NL) cmt_nxt = 1'b0;
      end else if (is_delim) begin
        if (mode_r != MODE_EMPTY) begin
          n        = 2'd1;
          mode_nxt = MODE_EMPTY;
          cand_nxt = '1;
          plen_nxt = '0;
          acc_nxt  = '0;
          seen_nxt = 1'b0;
          err_nxt  = fl_err;
        end
        // A comment is not entered once the flushed token was an error.
        if ((c == CH_SEMI) && !((mode_r != MODE_EMPTY) && fl_err)) cmt_nxt = 1'b1;
      end else if (kw_ext) begin
        cand_nxt = kwx;
        plen_nxt = plen_r + 1'b1;
        mode_nxt = MODE_KEYWORD;
      end else if ((mode_r == MODE_EMPTY) && (c == CH_ZERO)) begin
        mode_nxt = MODE_ZERO;
      end else if ((mode_r == MODE_ZERO) && (c == CH_X)) begin
        mode_nxt = MODE_HEX;
      end else if ((mode_r == MODE_HEX) && hex_ok && ovf) begin
        n       = 2'd1;
        r0      = ERR_RES;
        err_nxt = 1'b1;
      end else if ((mode_r == MODE_HEX) && hex_ok) begin
        acc_nxt  = {acc_r[VALUE_BITS-5:0], hex_val};
        seen_nxt = 1'b1;
      end else if (mode_r != MODE_EMPTY) begin
        // The character ends the token and, unless that token was an error, is lexed again from an empty buffer.
        n        = 2'd1;
        mode_nxt = MODE_EMPTY;
        cand_nxt = '1;
        plen_nxt = '0;
        acc_nxt  = '0;
        seen_nxt = 1'b0;
        if (fl_err) begin
          err_nxt = 1'b1;
        end else if (kw0_ext) begin
          cand_nxt = kw0;
          plen_nxt = LEN_W'(1);
          mode_nxt = MODE_KEYWORD;
        end else if (c == CH_ZERO) begin
          mode_nxt = MODE_ZERO;
        end else begin
          n       = 2'd2;
          err_nxt = 1'b1;
        end
      end else begin
        n       = 2'd1;
        r0      = ERR_RES;
        err_nxt = 1'b1;
      end
    end
    r0.last = (n == 2'd1);
    r1.last = 1'b1;
  end

  assign push = '{count: n, r0: r0, r1: r1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_EMPTY;
      cand_r <= '1;
      plen_r <= '0;
      acc_r  <= '0;
      seen_r <= 1'b0;
      cmt_r  <= 1'b0;
      err_r  <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      cand_r <= cand_nxt;
      plen_r <= plen_nxt;
      acc_r  <= acc_nxt;
      seen_r <= seen_nxt;
      cmt_r  <= cmt_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

// File: bench/assembler_keyword_hex_lexer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// assembler_keyword_hex_lexer_top_test
// Feeds source text to the lexer one character per request and holds a token
// predictor of its own. Each token that leaves the block is checked field by
// field against the oldest predicted one. Both channels idle at random.
// ----------------------------------------------------------------------------
module assembler_keyword_hex_lexer_top_test;

  localparam int RANDOM_ITEMS = 1950;
  localparam int QUIET_LIMIT  = 2000;
  localparam int SETTLE_WAIT  = 20;

  class token_scoreboard;

    typedef enum {MODE_EMPTY, MODE_WORD, MODE_ZERO, MODE_HEX} lex_mode_t;
    typedef enum {GROW_REJECT, GROW_TAKEN, GROW_OVERFLOW} grow_t;

    string words[akhl_pkg::KW_COUNT] = '{
      "SYS", "CLS", "RET", "JMP", "CALL", "SE", "SNE", "SKP", "SNKP", "KEY",
      "MOV", "ADD", "SUB", "RSB", "OR", "AND", "XOR", "SHR", "SHL", "RND",
      "DRW", "LDFNT", "BCD", "STR", "LDR",
      "V0", "V1", "V2", "V3", "V4", "V5", "V6", "V7",
      "V8", "V9", "VA", "VB", "VC", "VD", "VE", "VF"
    };

    logic [7:0]           pfx[akhl_pkg::KEYWORD_LEN];
    int                   pfx_len;
    lex_mode_t            mode;
    logic [63:0]          acc;
    bit                   digit_seen;
    bit                   skipping;
    bit                   err_latched;
    akhl_pkg::result_t    tokens_due[$];
    int                   fails;
    int                   tokens_seen;

    function new();
      clear_buffer();
      skipping    = 1'b0;
      err_latched = 1'b0;
      fails       = 0;
      tokens_seen = 0;
    endfunction

    function void clear_buffer();
      pfx_len    = 0;
      mode       = MODE_EMPTY;
      acc        = '0;
      digit_seen = 1'b0;
    endfunction

    function int pending();
      return tokens_due.size();
    endfunction

    function bit shares_prefix(int k);
      string w;
      w = words[k];
      for (int i = 0; i < pfx_len; i++) begin
        if (w[i] != pfx[i]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function bit word_grows(logic [7:0] c);
      string w;
      for (int k = 0; k < akhl_pkg::KW_COUNT; k++) begin
        w = words[k];
        if (w.len() > pfx_len && shares_prefix(k) && w[pfx_len] == c) return 1'b1;
      end
      return 1'b0;
    endfunction

    function int hex_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "A" && c <= "F") return c - "A" + 10;
      if (c >= "a" && c <= "f") return c - "a" + 10;
      return -1;
    endfunction

    function void push(akhl_pkg::kind_t kind, logic [5:0] code, logic [31:0] value);
      akhl_pkg::result_t t;
      t.kind  = kind;
      t.code  = code;
      t.value = value;
      t.last  = 1'b0;
      tokens_due.push_back(t);
      if (kind == akhl_pkg::KIND_ERROR) err_latched = 1'b1;
    endfunction

    function void flush_token();
      int hit;
      string w;
      hit = -1;
      if (mode == MODE_WORD) begin
        for (int k = 0; k < akhl_pkg::KW_COUNT; k++) begin
          w = words[k];
          if (hit < 0 && w.len() == pfx_len && shares_prefix(k)) hit = k;
        end
        if (hit >= 0) push(akhl_pkg::KIND_KEYWORD, hit[5:0], '0);
        else push(akhl_pkg::KIND_ERROR, '0, '0);
      end else if (mode == MODE_HEX && digit_seen) begin
        push(akhl_pkg::KIND_NUMBER, '0, acc[31:0]);
      end else begin
        push(akhl_pkg::KIND_ERROR, '0, '0);
      end
      clear_buffer();
    endfunction

    function grow_t grow(logic [7:0] c);
      int d;
      if ((mode == MODE_EMPTY || mode == MODE_WORD) && pfx_len < akhl_pkg::KEYWORD_LEN &&
          word_grows(c)) begin
        pfx[pfx_len] = c;
        pfx_len++;
        mode = MODE_WORD;
        return GROW_TAKEN;
      end
      if (mode == MODE_EMPTY && c == "0") begin
        mode = MODE_ZERO;
        return GROW_TAKEN;
      end
      if (mode == MODE_ZERO && c == "x") begin
        mode = MODE_HEX;
        return GROW_TAKEN;
      end
      if (mode == MODE_HEX) begin
        d = hex_value(c);
        if (d < 0) return GROW_REJECT;
        // The next digit would not fit in the value width.
        if ((acc >> (akhl_pkg::VALUE_BITS - 4)) != 0) return GROW_OVERFLOW;
        acc = (acc << 4) | 64'(d);
        digit_seen = 1'b1;
        return GROW_TAKEN;
      end
      return GROW_REJECT;
    endfunction

    // Predicts the tokens caused by one accepted character. Returns 0 when the
    // character is dropped because an error token is still latched.
    function bit note_char(logic [7:0] c, logic e);
      bit counted;
      int first;
      grow_t r;
      counted = !err_latched || e || c == 8'h00;
      first   = tokens_due.size();
      if (e || c == 8'h00) begin
        if (!err_latched && mode != MODE_EMPTY) flush_token();
        clear_buffer();
        skipping    = 1'b0;
        err_latched = 1'b0;
      end else if (err_latched) begin
      end else if (skipping) begin
        if (c == "\n") skipping = 1'b0;
      end else if (c == "\n" || c == ";" || c == " " || c == "\t" || c == ",") begin
        if (mode != MODE_EMPTY) flush_token();
        if (c == ";" && !err_latched) skipping = 1'b1;
      end else begin
        r = grow(c);
        if (r == GROW_OVERFLOW) begin
          push(akhl_pkg::KIND_ERROR, '0, '0);
        end else if (r == GROW_REJECT) begin
          if (mode != MODE_EMPTY) begin
            // The buffered token ends here and the character may start a new one.
            flush_token();
            if (!err_latched && grow(c) != GROW_TAKEN) push(akhl_pkg::KIND_ERROR, '0, '0);
          end else begin
            push(akhl_pkg::KIND_ERROR, '0, '0);
          end
        end
      end
      if (tokens_due.size() > first) tokens_due[tokens_due.size() - 1].last = 1'b1;
      return counted;
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      fails++;
    endtask

    task check_token(logic [1:0] kind, logic [5:0] code, logic [31:0] value, logic last);
      akhl_pkg::result_t want;
      tokens_seen++;
      if (tokens_due.size() == 0) begin
        report($sformatf("token %0d not expected: kind %0d code %0d value %h last %b",
                         tokens_seen, kind, code, value, last));
        return;
      end
      want = tokens_due.pop_front();
      if (kind !== want.kind)
        report($sformatf("token %0d kind %0d, want %0d", tokens_seen, kind, want.kind));
      if (code !== want.code)
        report($sformatf("token %0d code %0d, want %0d", tokens_seen, code, want.code));
      if (value !== want.value)
        report($sformatf("token %0d value %h, want %h", tokens_seen, value, want.value));
      if (last !== want.last)
        report($sformatf("token %0d last %b, want %b", tokens_seen, last, want.last));
    endtask

  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [akhl_pkg::CHAR_W-1:0]   in_text_char;
  logic                          in_end_of_text;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [1:0]                    out_token_kind;
  logic [akhl_pkg::CODE_W-1:0]   out_keyword_code;
  logic [akhl_pkg::NUMBER_W-1:0] out_number_value;
  logic                          out_last_of_run;

  token_scoreboard sb = new();
  int items_done;
  int send_steady;
  int recv_steady;
  int ready_hold;
  int quiet_cycles;

  assembler_keyword_hex_lexer_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_text_char     (in_text_char),
    .in_end_of_text   (in_end_of_text),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_keyword_code (out_keyword_code),
    .out_number_value (out_number_value),
    .out_last_of_run  (out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly no gap, some short ones, a few long ones, and now and then a
  // stretch with no gaps at all.
  function automatic int gap_len(inout int steady);
    int r;
    if (steady > 0) begin
      steady--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      steady = $urandom_range(20, 100);
      return 0;
    end
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      ready_hold = gap_len(recv_steady);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_token(out_token_kind, out_keyword_code, out_number_value, out_last_of_run);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no request moved for %0d cycles", QUIET_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_char(input logic [7:0] c, input logic e);
    int gap;
    gap = gap_len(send_steady);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_text_char   <= c;
    in_end_of_text <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (sb.note_char(c, e)) items_done++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
  endtask

  task automatic send_separator();
    string seps;
    seps = " \t,\n";
    send_char(seps[$urandom_range(0, 3)], 1'b0);
  endtask

  task automatic send_keyword();
    string w;
    int n;
    w = sb.words[$urandom_range(0, akhl_pkg::KW_COUNT - 1)];
    n = w.len();
    // Now and then only a prefix, which matches no keyword on its own.
    if ($urandom_range(0, 9) == 0) n = $urandom_range(1, n - 1);
    for (int i = 0; i < n; i++) send_char(w[i], 1'b0);
  endtask

  task automatic send_literal();
    string digits;
    int r;
    int n;
    digits = "0123456789abcdefABCDEF";
    send_char("0", 1'b0);
    r = $urandom_range(0, 99);
    if (r < 4) begin
      send_char("X", 1'b0);
    end else if (r < 92) begin
      send_char("x", 1'b0);
      r = $urandom_range(0, 99);
      if (r < 6) n = 0;
      else if (r < 85) n = $urandom_range(1, 8);
      else n = $urandom_range(9, 10);
      for (int i = 0; i < n; i++) send_char(digits[$urandom_range(0, 21)], 1'b0);
    end
  endtask

  task automatic send_comment();
    logic [7:0] c;
    int n;
    send_char(";", 1'b0);
    n = $urandom_range(0, 6);
    for (int i = 0; i < n; i++) begin
      c = 8'($urandom_range(1, 255));
      if (c == "\n") c = "#";
      send_char(c, 1'b0);
    end
    if ($urandom_range(0, 9) != 0) send_char("\n", 1'b0);
  endtask

  task automatic send_end();
    if ($urandom_range(0, 1)) send_char(8'($urandom_range(0, 255)), 1'b1);
    else send_char(8'h00, 1'b0);
  endtask

  task automatic send_random_chunk();
    int r;
    r = $urandom_range(0, 99);
    if (sb.err_latched) begin
      // Keep the time spent in the dropped state short.
      if (r < 80) send_end();
      else send_char(8'($urandom_range(1, 255)), 1'b0);
    end else if (r < 35) begin
      send_keyword();
      if ($urandom_range(0, 9) < 7) send_separator();
    end else if (r < 55) begin
      send_literal();
      if ($urandom_range(0, 9) < 7) send_separator();
    end else if (r < 63) begin
      send_comment();
    end else if (r < 73) begin
      send_separator();
    end else if (r < 80) begin
      send_end();
    end else if (r < 88) begin
      send_char(8'($urandom_range("A", "Z")), 1'b0);
    end else begin
      send_char(8'($urandom_range(1, 255)), 1'b0);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_text_char   = '0;
    in_end_of_text = 1'b0;
    items_done     = 0;
    send_steady    = 0;
    recv_steady    = 0;
    ready_hold     = 0;
    quiet_cycles   = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // The longest keyword and the last register, then a comment holding the
    // top character code.
    send_text("LDFNT VF;");
    send_char(8'hFF, 1'b0);
    send_char("\n", 1'b0);
    // The largest literal that fits, ended by a comma.
    send_text("0xFFFFFFFF,");
    // An empty literal cut by a high character code, then an end request
    // whose character is dropped.
    send_text("0x");
    send_char(8'h80, 1'b0);
    send_char(8'h7F, 1'b1);
    // A bare keyword prefix flushed by a NUL character.
    send_text("AD");
    send_char(8'h00, 1'b0);

    items_done = 0;
    while (items_done < RANDOM_ITEMS) send_random_chunk();
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
    if (sb.fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
